// ===== rtl/core/tcp_pkg.sv =====
// ---------------------------------------------------------------------------
// time code line parser package
// shared types, character codes and field helpers
// ---------------------------------------------------------------------------
package tcp_pkg;

   // characters of interest on the line
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_N     = 8'h4E;

   // capture window from the dash: 20 characters, entries 1..18 are read
   localparam int CAP_LEN   = 20;
   localparam int CAP_FIRST = 1;
   localparam int CAP_LAST  = 18;
   localparam int CAP_CNT_W = 5;

   // "NO CARRIER"
   localparam int PAT_LEN   = 10;
   localparam int PAT_W     = 4;

   // year mapping and daylight code window
   localparam logic signed [12:0] YEAR_BASE  = 13'sd1900;
   localparam logic signed [12:0] YEAR_PIVOT = 13'sd1990;
   localparam logic signed [12:0] CENTURY    = 13'sd100;
   localparam logic signed [7:0]  DST_LOW    = 8'sd2;
   localparam logic signed [7:0]  DST_HIGH   = 8'sd51;

   localparam logic signed [4:0] ZONE_RESET = -5'sd7;

   localparam int TIME_W = 40;
   localparam logic [TIME_W-1:0] NEVER_TIME = '1;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_CARRIER = 3'd1,
      ST_OVERFLOW   = 3'd2,
      ST_FORMAT_BAD = 3'd3,
      ST_RANGE_BAD  = 3'd4
   } status_type;

   // what the capture stage shows the decoder
   typedef struct packed {
      logic                         carrier_seen;
      logic                         frame_ok;
      logic [1:0][7:0]              lead;
      logic [CAP_LAST:CAP_FIRST][7:0] cap;
   } line_view_type;

   // classification of the byte being processed
   typedef struct packed {
      logic skip;
      logic ends_line;
      logic overflow;
   } line_event_type;

   typedef struct packed {
      status_type  status;
      logic [11:0] year;
      logic [3:0]  month;
      logic [5:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        confirmed;
   } result_type;

   function automatic logic carrier_char_match(logic [PAT_W-1:0] idx, logic [7:0] c);
      logic [7:0] p;
      case (idx)
         4'd0:    p = 8'h4E; // N
         4'd1:    p = 8'h4F; // O
         4'd2:    p = 8'h20;
         4'd3:    p = 8'h43; // C
         4'd4:    p = 8'h41; // A
         4'd5:    p = 8'h52; // R
         4'd6:    p = 8'h52; // R
         4'd7:    p = 8'h49; // I
         4'd8:    p = 8'h45; // E
         4'd9:    p = 8'h52; // R
         default: p = 8'h00;
      endcase
      return (idx < 4'(PAT_LEN)) && (c == p);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c inside {CHAR_SPACE, [8'h09:8'h0D]};
   endfunction

   // two character field read like a c integer parse
   function automatic logic signed [7:0] parse2(logic [7:0] c0, logic [7:0] c1);
      logic signed [7:0] d0;
      logic signed [7:0] d1;
      logic signed [7:0] v;
      d0 = {4'b0000, c0[3:0]};
      d1 = is_digit(c1) ? {4'b0000, c1[3:0]} : 8'sd0;
      if (is_space(c0) || c0 == CHAR_PLUS) begin
         v = d1;
      end else if (c0 == CHAR_DASH) begin
         v = -d1;
      end else if (is_digit(c0)) begin
         v = is_digit(c1) ? (d0 <<< 3) + (d0 <<< 1) + d1 : d0;
      end else begin
         v = 8'sd0;
      end
      return v;
   endfunction

endpackage

// ===== rtl/core/tcp_channel_if.sv =====
// ---------------------------------------------------------------------------
// time code line parser channels
// valid/ready request and response channels
// ---------------------------------------------------------------------------
interface tcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       marker_ends_line;

   modport source (output valid, output rx_byte, output marker_ends_line, input ready);
   modport sink   (input valid, input rx_byte, input marker_ends_line, output ready);
endinterface

interface tcp_rsp_if;
   logic                valid;
   logic                ready;
   tcp_pkg::status_type status;
   logic [11:0]         year;
   logic [3:0]          month;
   logic [5:0]          day;
   logic [4:0]          hour;
   logic [5:0]          minute;
   logic [5:0]          second;
   logic                confirmed;

   modport source (output valid, output status, output year, output month, output day,
                   output hour, output minute, output second, output confirmed,
                   input ready);
   modport sink   (input valid, input status, input year, input month, input day,
                   input hour, input minute, input second, input confirmed,
                   output ready);
endinterface

// ===== rtl/core/tcp_line_capture.sv =====
// ---------------------------------------------------------------------------
// time code line capture
// per-character line state: position, dash anchor, capture window, carrier match
// ---------------------------------------------------------------------------
module tcp_line_capture #(
   parameter int LINE_MAX = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             rx_byte,
   input  logic                   marker_ends_line,
   output tcp_pkg::line_event_type line_event,
   output tcp_pkg::line_view_type  line_view
);
   import tcp_pkg::*;

   localparam int POS_W = $clog2(LINE_MAX);

   logic [POS_W-1:0]               pos_ff, pos_in;
   logic                           dash_found_ff, dash_found_in;
   logic                           dash_early_ff, dash_early_in;
   logic [1:0][7:0]                recent_ff, recent_in;
   logic [CAP_CNT_W-1:0]           cap_cnt_ff, cap_cnt_in;
   logic [PAT_W-1:0]               prog_ff, prog_in;
   logic [CAP_LAST:CAP_FIRST][7:0] cap_ff;
   logic                           cap_write;

   always_comb begin
      line_event.skip      = (rx_byte == CHAR_LF);
      line_event.ends_line = (rx_byte == CHAR_CR) ||
                             (marker_ends_line && (rx_byte == CHAR_STAR || rx_byte == CHAR_HASH));
      line_event.overflow  = !line_event.skip && !line_event.ends_line &&
                             (pos_ff == POS_W'(LINE_MAX - 1));
   end

   always_comb begin
      pos_in        = pos_ff;
      dash_found_in = dash_found_ff;
      dash_early_in = dash_early_ff;
      recent_in     = recent_ff;
      cap_cnt_in    = cap_cnt_ff;
      prog_in       = prog_ff;
      cap_write     = 1'b0;
      if (step && !line_event.skip) begin
         if (line_event.ends_line || line_event.overflow) begin
            pos_in        = '0;
            dash_found_in = 1'b0;
            dash_early_in = 1'b0;
            recent_in     = '0;
            cap_cnt_in    = '0;
            prog_in       = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (!dash_found_ff) begin
               if (rx_byte == CHAR_DASH) begin
                  dash_found_in = 1'b1;
                  dash_early_in = (pos_ff < POS_W'(2));
                  cap_cnt_in    = CAP_CNT_W'(1);
               end else begin
                  recent_in = {rx_byte, recent_ff[1]};
               end
            end else if (cap_cnt_ff < CAP_CNT_W'(CAP_LEN)) begin
               cap_write  = 1'b1;
               cap_cnt_in = cap_cnt_ff + 1'b1;
            end
            // carrier match stops moving once the whole phrase is seen
            if (prog_ff < PAT_W'(PAT_LEN)) begin
               if (carrier_char_match(prog_ff, rx_byte)) begin
                  prog_in = prog_ff + 1'b1;
               end else begin
                  prog_in = (rx_byte == CHAR_N) ? PAT_W'(1) : '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         dash_found_ff <= 1'b0;
         dash_early_ff <= 1'b0;
         recent_ff     <= '0;
         cap_cnt_ff    <= '0;
         prog_ff       <= '0;
      end else begin
         pos_ff        <= pos_in;
         dash_found_ff <= dash_found_in;
         dash_early_ff <= dash_early_in;
         recent_ff     <= recent_in;
         cap_cnt_ff    <= cap_cnt_in;
         prog_ff       <= prog_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = CAP_FIRST; i <= CAP_LAST; i++) begin
         if (cap_write && cap_cnt_ff == CAP_CNT_W'(i)) begin
            cap_ff[i] <= rx_byte;
         end
      end
   end

   always_comb begin
      line_view.carrier_seen = (prog_ff >= PAT_W'(PAT_LEN));
      line_view.frame_ok     = dash_found_ff && !dash_early_ff &&
                               (cap_cnt_ff == CAP_CNT_W'(CAP_LEN));
      line_view.lead         = recent_ff;
      line_view.cap          = cap_ff;
   end

endmodule

// ===== rtl/core/tcp_field_decode.sv =====
// ---------------------------------------------------------------------------
// time code field decode
// separator check, field parse, range check, daylight and zone adjustment
// ---------------------------------------------------------------------------
module tcp_field_decode (
   input  tcp_pkg::line_view_type       line_view,
   input  logic                         overflow,
   input  logic signed [4:0]            zone_offset_hours,
   input  logic [tcp_pkg::TIME_W-1:0]   expected_time,
   output tcp_pkg::result_type          result,
   output logic [tcp_pkg::TIME_W-1:0]   next_expected
);
   import tcp_pkg::*;

   logic signed [7:0]  yy, mo, dd, hh, mi, ss, dst;
   logic signed [12:0] year_full;
   logic signed [6:0]  hour_adj;
   logic [5:0]         day_adj;
   logic [4:0]         hour_out;
   logic [3:0]         month_out;
   logic               seps_ok, range_ok;
   logic [TIME_W-1:0]  now_time;

   always_comb begin
      yy  = parse2(line_view.lead[0], line_view.lead[1]);
      mo  = parse2(line_view.cap[1],  line_view.cap[2]);
      dd  = parse2(line_view.cap[4],  line_view.cap[5]);
      hh  = parse2(line_view.cap[7],  line_view.cap[8]);
      mi  = parse2(line_view.cap[10], line_view.cap[11]);
      ss  = parse2(line_view.cap[13], line_view.cap[14]);
      dst = parse2(line_view.cap[16], line_view.cap[17]);

      seps_ok = line_view.cap[3] == CHAR_DASH && line_view.cap[6] == CHAR_SPACE &&
                line_view.cap[9] == CHAR_COLON && line_view.cap[12] == CHAR_COLON &&
                line_view.cap[15] == CHAR_SPACE && line_view.cap[18] == CHAR_SPACE;

      range_ok = mo >= 8'sd0 && mo <= 8'sd12 && dd >= 8'sd1 && dd <= 8'sd31 &&
                 hh >= 8'sd0 && hh <= 8'sd23 && mi >= 8'sd0 && mi <= 8'sd59 &&
                 ss >= 8'sd0 && ss <= 8'sd59;

      year_full = YEAR_BASE + 13'(yy);
      if (year_full < YEAR_PIVOT) begin
         year_full = year_full + CENTURY;
      end
      month_out = (mo == 8'sd0) ? 4'd12 : mo[3:0];

      // daylight hour, then zone offset with a single day carry
      hour_adj = 7'(hh) + 7'(zone_offset_hours) +
                 ((dst >= DST_LOW && dst <= DST_HIGH) ? 7'sd1 : 7'sd0);
      day_adj  = dd[5:0];
      if (hour_adj < 7'sd0) begin
         hour_adj = hour_adj + 7'sd24;
         day_adj  = day_adj - 1'b1;
      end else if (hour_adj > 7'sd23) begin
         hour_adj = hour_adj - 7'sd24;
         day_adj  = day_adj + 1'b1;
      end
      hour_out = hour_adj[4:0];

      now_time = {year_full[11:0], month_out, day_adj, hour_out, mi[5:0], 1'b0, ss[5:0]};

      result = '0;
      if (overflow) begin
         result.status = ST_OVERFLOW;
      end else if (line_view.carrier_seen) begin
         result.status = ST_NO_CARRIER;
      end else if (!line_view.frame_ok || !seps_ok) begin
         result.status = ST_FORMAT_BAD;
      end else if (!range_ok) begin
         result.status = ST_RANGE_BAD;
      end else begin
         result.status    = ST_OK;
         result.year      = year_full[11:0];
         result.month     = month_out;
         result.day       = day_adj;
         result.hour      = hour_out;
         result.minute    = mi[5:0];
         result.second    = ss[5:0];
         result.confirmed = (now_time == expected_time);
      end

      // seconds sit in a 7-bit slot, so adding one never carries upward
      next_expected = (result.status == ST_OK) ? now_time + 1'b1 : NEVER_TIME;
   end

endmodule

// ===== rtl/core/time_code_line_parser_unit.sv =====
// ---------------------------------------------------------------------------
// time code line parser unit
// parses a dial-up time service line one received character per request
// ---------------------------------------------------------------------------
// usage:
//  - req_port carries one received character (rx_byte) and marker_ends_line
//    per request; LF is dropped, CR ends the line, and with the marker set
//    '*' or '#' end it too
//  - rsp_port carries one response per ended line: status, the local date
//    and time, and confirmed when the previous line was good and this time
//    is its time plus a second
//  - csr_write_enable / csr_write_data load the signed zone offset in hours;
//    write it only while no request is in flight
//  - every request passes through the input register and then the capture
//    and decode logic; the response to the ending character is registered
//    in the response register
//  - throughput is one request per cycle unless the response stalls, set by
//    the single registered pass from input register to response register
//  - a waiting response does not block the input while the input register is
//    free; when the response is stalled and the input register is full,
//    req_port.ready drops until the response is taken
//  - reset (synchronous) empties both registers, clears the line state, sets
//    the zone offset to -7 and the expected time to never matching
// ---------------------------------------------------------------------------
module time_code_line_parser_unit #(
   parameter int LINE_MAX = 256
) (
   input  logic              clock,
   input  logic              reset,
   tcp_req_if.sink           req_port,
   tcp_rsp_if.source         rsp_port,
   input  logic              csr_write_enable,
   input  logic signed [4:0] csr_write_data
);
   import tcp_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_marker_ff;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   logic signed [4:0]  zone_ff;
   logic [TIME_W-1:0]  expected_ff;

   logic               req_take;
   logic               advance;
   logic               step;
   logic               emit;
   line_event_type     line_event;
   line_view_type      line_view;
   result_type         result;
   logic [TIME_W-1:0]  next_expected;

   // the pass moves whenever the response register is empty or being emptied
   assign advance  = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = !in_valid_ff || advance;
   assign req_take = req_port.valid && req_port.ready;
   assign step     = in_valid_ff && advance;
   assign emit     = step && (line_event.ends_line || line_event.overflow);

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_port.ready);

   tcp_line_capture #(
      .LINE_MAX (LINE_MAX)
   ) u_capture (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .rx_byte          (in_byte_ff),
      .marker_ends_line (in_marker_ff),
      .line_event       (line_event),
      .line_view        (line_view)
   );

   tcp_field_decode u_decode (
      .line_view         (line_view),
      .overflow          (line_event.overflow),
      .zone_offset_hours (zone_ff),
      .expected_time     (expected_ff),
      .result            (result),
      .next_expected     (next_expected)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         zone_ff      <= ZONE_RESET;
         expected_ff  <= NEVER_TIME;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            zone_ff <= csr_write_data;
         end
         if (emit) begin
            expected_ff <= next_expected;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff   <= req_port.rx_byte;
         in_marker_ff <= req_port.marker_ends_line;
      end
      if (emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.status    = rsp_data_ff.status;
   assign rsp_port.year      = rsp_data_ff.year;
   assign rsp_port.month     = rsp_data_ff.month;
   assign rsp_port.day       = rsp_data_ff.day;
   assign rsp_port.hour      = rsp_data_ff.hour;
   assign rsp_port.minute    = rsp_data_ff.minute;
   assign rsp_port.second    = rsp_data_ff.second;
   assign rsp_port.confirmed = rsp_data_ff.confirmed;

   // a failed line always drops the expected time back to never matching
   a_fail_clears_expected: assert property (@(posedge clock) disable iff (reset)
      emit && result.status != ST_OK |=> expected_ff == NEVER_TIME)
      else $error("expected time kept after a failed line");

   // a good response carries a mapped month and a wrapped hour
   a_ok_fields_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == ST_OK |->
         rsp_data_ff.month >= 4'd1 && rsp_data_ff.month <= 4'd12 &&
         rsp_data_ff.hour <= 5'd23 && rsp_data_ff.year >= 12'd1990)
      else $error("good response with a field out of range");

   // a failed response has its time fields zeroed
   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != ST_OK |->
         rsp_data_ff.year == 12'd0 && rsp_data_ff.hour == 5'd0 && !rsp_data_ff.confirmed)
      else $error("failed response with time fields set");

   // a held request is neither lost nor overwritten while the pass is stalled
   a_stall_keeps_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input register changed while stalled");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// time code line parser testbench
// drives received characters into the parser, predicts every response with
// an independent line decoder and checks each response field by field;
// a short table of hand-made lines comes first, then random time service
// lines, noise and overflow lines under several zone offsets
// ---------------------------------------------------------------------------
module tb;
   import tcp_pkg::*;

   localparam int LINE_MAX      = 256;
   localparam int CENTURY_START = 1900;
   localparam int PIVOT_YEAR    = 1990;
   localparam logic [7:0] DIGIT_0 = "0";
   localparam logic [7:0] DIGIT_9 = "9";
   localparam logic [7:0] FILL_CHAR = "x";
   localparam logic [63:0] NEVER_STAMP = 64'h00FF_FFFF_FFFF;

   // clock, reset and the block's ports
   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic signed [4:0] csr_write_data;

   tcp_req_if req_bus ();
   tcp_rsp_if rsp_bus ();

   time_code_line_parser_unit #(.LINE_MAX(LINE_MAX)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_bus),
      .rsp_port         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // decoder copy of the line state
   logic [8:0]        line_len;
   logic              dash_seen;
   logic [8:0]        dash_at;
   logic [7:0]        lead_chars [2];
   logic [7:0]        window [CAP_LEN];
   logic [3:0]        carrier_hits;
   logic [63:0]       next_stamp;
   logic signed [4:0] zone_hours;
   string             carrier_word = "NO CARRIER";

   // responses still owed by the block, oldest first
   result_type pending_lines[$];

   int  mismatches;
   int  sent_count;
   bit  sender_calm;

   // random time kept between lines so that seconds can step by one
   int tm_y, tm_mo, tm_d, tm_h, tm_mi, tm_s, tm_dst;

   // hand-made lines: text, optional typed-in status for error lines
   typedef struct {
      string      text;
      bit         fixed;
      status_type code;
      bit         mark;
      int         fill;
      bit         nul_first;
   } line_row_type;
   line_row_type directed_rows[$];

   // 12 ns clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // run limit: a run that has not finished by this time is failed
   initial begin
      #(10_000_000);
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // line decoder
   // ------------------------------------------------------------------------
   function automatic bit is_numeral(logic [7:0] c);
      return c >= DIGIT_0 && c <= DIGIT_9;
   endfunction

   // two character number read like a c integer parse
   function automatic int read_field(logic [7:0] a, logic [7:0] b);
      int lo;
      lo = is_numeral(b) ? int'(b - DIGIT_0) : 0;
      if (a == CHAR_SPACE || (a >= 8'd9 && a <= 8'd13) || a == CHAR_PLUS) return lo;
      if (a == CHAR_DASH) return -lo;
      if (is_numeral(a)) return is_numeral(b) ? int'(a - DIGIT_0) * 10 + lo : int'(a - DIGIT_0);
      return 0;
   endfunction

   task automatic clear_line();
      line_len      = '0;
      dash_seen     = 1'b0;
      dash_at       = '0;
      lead_chars[0] = '0;
      lead_chars[1] = '0;
      carrier_hits  = '0;
   endtask

   // works out the response of an ended line and clears the line
   task automatic finish_line(input status_type st, output result_type r);
      int          y, mo, d, h, mi, s, dst;
      logic [63:0] stamp;
      status_type  code;
      code = st;
      r = '0;
      if (code == ST_OK) begin
         if (!dash_seen || dash_at < 2 || int'(line_len) < int'(dash_at) + CAP_LEN)
            code = ST_FORMAT_BAD;
         else if (window[3] != CHAR_DASH || window[6] != CHAR_SPACE ||
                  window[9] != CHAR_COLON || window[12] != CHAR_COLON ||
                  window[15] != CHAR_SPACE || window[18] != CHAR_SPACE)
            code = ST_FORMAT_BAD;
      end
      if (code == ST_OK) begin
         y = CENTURY_START + read_field(lead_chars[0], lead_chars[1]);
         if (y < PIVOT_YEAR) y += 100;
         mo  = read_field(window[1], window[2]);
         d   = read_field(window[4], window[5]);
         h   = read_field(window[7], window[8]);
         mi  = read_field(window[10], window[11]);
         s   = read_field(window[13], window[14]);
         dst = read_field(window[16], window[17]);
         if (mo < 0 || mo > 12 || d < 1 || d > 31 || h < 0 || h > 23 ||
             mi < 0 || mi > 59 || s < 0 || s > 59)
            code = ST_RANGE_BAD;
      end
      if (code == ST_OK) begin
         if (mo == 0) mo = 12;
         // daylight hour, then the zone with a single day carry
         if (dst >= 2 && dst <= 51) h++;
         h += int'(zone_hours);
         if (h < 0) begin
            h += 24;
            d--;
         end
         if (h > 23) begin
            h -= 24;
            d++;
         end
         stamp = (64'(y) << 28) | (64'(mo) << 24) | (64'(d) << 18) |
                 (64'(h) << 13) | (64'(mi) << 7) | 64'(s);
         r.year      = 12'(y);
         r.month     = 4'(mo);
         r.day       = 6'(d);
         r.hour      = 5'(h);
         r.minute    = 6'(mi);
         r.second    = 6'(s);
         r.confirmed = (stamp == next_stamp);
         next_stamp  = stamp + 64'd1;
      end else begin
         next_stamp = NEVER_STAMP;
      end
      r.status = code;
      clear_line();
   endtask

   // one accepted character; got is set when it ends a line
   task automatic decode_char(input logic [7:0] c, input logic m, output bit got,
                              output result_type r);
      int p;
      got = 1'b0;
      r = '0;
      if (c == CHAR_LF) return;
      if (c == CHAR_CR || (m && (c == CHAR_STAR || c == CHAR_HASH))) begin
         finish_line(carrier_hits >= 4'(PAT_LEN) ? ST_NO_CARRIER : ST_OK, r);
         got = 1'b1;
         return;
      end
      p = int'(line_len);
      if (!dash_seen) begin
         if (c == CHAR_DASH) begin
            dash_seen = 1'b1;
            dash_at   = 9'(p);
            window[0] = c;
         end else begin
            lead_chars[0] = lead_chars[1];
            lead_chars[1] = c;
         end
      end else if (p - int'(dash_at) < CAP_LEN) begin
         window[p - int'(dash_at)] = c;
      end
      if (carrier_hits < 4'(PAT_LEN)) begin
         if (c == carrier_word[carrier_hits]) carrier_hits++;
         else carrier_hits = (c == CHAR_N) ? 4'd1 : 4'd0;
      end
      line_len = 9'(p + 1);
      if (p + 1 >= LINE_MAX) begin
         finish_line(ST_OVERFLOW, r);
         got = 1'b1;
      end
   endtask

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (sender_calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // one request; valid stays high afterwards so back-to-back requests need
   // no second assignment in the same step
   task automatic send_char(input logic [7:0] c, input logic m, input bit fixed,
                            input result_type fixed_res);
      int         gap;
      bit         got;
      result_type r;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.rx_byte          <= c;
      req_bus.marker_ends_line <= m;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      decode_char(c, m, got, r);
      if (got) pending_lines.push_back(fixed ? fixed_res : r);
      if (c != CHAR_LF) sent_count++;
   endtask

   // a whole line, with the odd stray LF; marker only matters on '*' and '#'
   task automatic send_line(ref logic [7:0] q[$], input logic m, input bit fixed,
                            input status_type code);
      result_type fixed_res;
      logic       bit_m;
      fixed_res = '0;
      fixed_res.status = code;
      sender_calm = ($urandom_range(0, 99) < 20);
      foreach (q[k]) begin
         if ($urandom_range(0, 99) < 3) send_char(CHAR_LF, 1'($urandom_range(0, 1)), 1'b0, '0);
         bit_m = (q[k] == CHAR_STAR || q[k] == CHAR_HASH) ? m : 1'($urandom_range(0, 1));
         send_char(q[k], bit_m, fixed && (k == q.size() - 1), fixed_res);
      end
   endtask

   // sender holds off until every owed response has been taken
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
   endtask

   // zone offset is only changed with the block idle
   task automatic set_zone(input int z);
      drain_results();
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= 5'(z);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      zone_hours = 5'(z);
   endtask

   // ------------------------------------------------------------------------
   // random line builders
   // ------------------------------------------------------------------------
   function automatic logic [7:0] text_char();
      logic [7:0] c;
      do c = 8'($urandom_range(32, 126));
      while (c == CHAR_STAR || c == CHAR_HASH);
      return c;
   endfunction

   function automatic int pick_value(int lo, int hi);
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return lo;
      if (r < 24) return hi;
      if (r < 28) return hi + 1;
      return $urandom_range(lo, hi);
   endfunction

   // two character field, now and then in an unusual spelling
   task automatic push_field(ref logic [7:0] q[$], input int v, input bit signs);
      int r;
      logic [7:0] dig;
      r = $urandom_range(0, 99);
      dig = 8'($urandom_range(DIGIT_0, DIGIT_9));
      if (r < 3) begin
         q.push_back(CHAR_SPACE);
         q.push_back(dig);
      end else if (r < 5) begin
         q.push_back(CHAR_PLUS);
         q.push_back(dig);
      end else if (r < 7 && signs) begin
         q.push_back(CHAR_DASH);
         q.push_back(dig);
      end else if (r < 9) begin
         q.push_back(dig);
         q.push_back(8'($urandom_range("A", "Z")));
      end else begin
         q.push_back(DIGIT_0 + 8'(v / 10));
         q.push_back(DIGIT_0 + 8'(v % 10));
      end
   endtask

   task automatic build_time_line(ref logic [7:0] q[$], input logic m);
      int         r, k, bad_sep;
      logic [7:0] seps [6];
      // step the seconds on often so that confirmed comes up
      if ($urandom_range(0, 99) < 45 && tm_s < 59) begin
         tm_s++;
      end else begin
         r = $urandom_range(0, 99);
         tm_y   = (r < 15) ? 89 : (r < 30) ? 90 : (r < 40) ? 0 : (r < 50) ? 99
                                              : $urandom_range(0, 99);
         tm_mo  = pick_value(0, 12);
         tm_d   = pick_value(1, 31);
         tm_h   = pick_value(0, 23);
         tm_mi  = pick_value(0, 59);
         tm_s   = pick_value(0, 59);
         r = $urandom_range(0, 99);
         tm_dst = (r < 15) ? 0 : (r < 25) ? 1 : (r < 35) ? 2 : (r < 45) ? 51 : (r < 55) ? 52
                                          : $urandom_range(0, 99);
      end
      seps = '{CHAR_DASH, CHAR_SPACE, CHAR_COLON, CHAR_COLON, CHAR_SPACE, CHAR_SPACE};
      if ($urandom_range(0, 99) < 8) begin
         bad_sep = $urandom_range(0, 5);
         seps[bad_sep] = text_char();
      end
      // day number and a space, nothing, or a few letters before the year
      r = $urandom_range(0, 99);
      if (r < 60) begin
         repeat (5) q.push_back(8'($urandom_range(DIGIT_0, DIGIT_9)));
         q.push_back(CHAR_SPACE);
      end else if (r >= 80) begin
         repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range("A", "Z")));
      end
      push_field(q, tm_y, 1'b0);
      q.push_back(CHAR_DASH);
      push_field(q, tm_mo, 1'b1);
      q.push_back(seps[0]);
      push_field(q, tm_d, 1'b1);
      q.push_back(seps[1]);
      push_field(q, tm_h, 1'b1);
      q.push_back(seps[2]);
      push_field(q, tm_mi, 1'b1);
      q.push_back(seps[3]);
      push_field(q, tm_s, 1'b1);
      q.push_back(seps[4]);
      push_field(q, tm_dst, 1'b1);
      q.push_back(seps[5]);
      // tail; an empty one leaves the line a character short
      k = ($urandom_range(0, 99) < 10) ? 0 : $urandom_range(1, 25);
      repeat (k) q.push_back(text_char());
      if ($urandom_range(0, 99) < 4) begin
         for (int i = 0; i < carrier_word.len(); i++) q.push_back(carrier_word[i]);
      end
      r = $urandom_range(0, 2);
      q.push_back(!m || r == 0 ? CHAR_CR : (r == 1) ? CHAR_STAR : CHAR_HASH);
   endtask

   task automatic add_row(input string text, input bit fixed, input status_type code,
                          input bit mark, input int fill, input bit nul_first);
      line_row_type row;
      row.text      = text;
      row.fixed     = fixed;
      row.code      = code;
      row.mark      = mark;
      row.fill      = fill;
      row.nul_first = nul_first;
      directed_rows.push_back(row);
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   initial begin : rsp_stall_gen
      int run_len;
      int pick;
      rsp_bus.ready = 1'b0;
      forever begin
         // ready stretches, now and then long ones with no stall at all
         pick = $urandom_range(0, 99);
         run_len = (pick < 10) ? $urandom_range(50, 200) : $urandom_range(1, 12);
         repeat (run_len) begin
            @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end
         pick = $urandom_range(0, 99);
         run_len = (pick < 50) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
         repeat (run_len) begin
            @(posedge clock);
            rsp_bus.ready <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // every accepted response against the oldest owed one
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_lines.size() == 0) begin
            $display("%0t: response with none owed, expected nothing, actual status %0d",
                     $time, int'(rsp_bus.status));
            mismatches++;
         end else begin
            want = pending_lines.pop_front();
            check_field("status", int'(want.status), int'(rsp_bus.status));
            check_field("year", int'(want.year), int'(rsp_bus.year));
            check_field("month", int'(want.month), int'(rsp_bus.month));
            check_field("day", int'(want.day), int'(rsp_bus.day));
            check_field("hour", int'(want.hour), int'(rsp_bus.hour));
            check_field("minute", int'(want.minute), int'(rsp_bus.minute));
            check_field("second", int'(want.second), int'(rsp_bus.second));
            check_field("confirmed", int'(want.confirmed), int'(rsp_bus.confirmed));
         end
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [7:0]   line_q[$];
      line_row_type row;
      int           zone_plan [7];
      int           phase_start;
      int           r;
      logic         m;
      bit           paused;

      // known values on every input from time zero
      reset                    = 1'b1;
      csr_write_enable         = 1'b0;
      csr_write_data           = '0;
      req_bus.valid            = 1'b0;
      req_bus.rx_byte          = '0;
      req_bus.marker_ends_line = 1'b0;
      mismatches  = 0;
      sent_count  = 0;
      sender_calm = 1'b0;
      paused      = 1'b0;
      tm_y = 24; tm_mo = 1; tm_d = 1; tm_h = 0; tm_mi = 0; tm_s = 0; tm_dst = 0;

      // decoder state after reset
      clear_line();
      foreach (window[i]) window[i] = '0;
      next_stamp = NEVER_STAMP;
      zone_hours = ZONE_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // hand-made lines under the reset zone offset
      add_row("90-01-01 07:00:00 00 0\r", 0, ST_OK, 0, 0, 0);          // earliest year
      add_row("89-12-31 23:59:59 51 0\r", 0, ST_OK, 0, 0, 0);          // latest year, last dst
      add_row("NO CARRIER\r", 1, ST_NO_CARRIER, 0, 0, 0);
      add_row("NNO CARRIER 24-01-02 03:04:05 06 7\r", 1, ST_NO_CARRIER, 0, 0, 0);
      add_row("NO CARRIE\r", 1, ST_FORMAT_BAD, 0, 0, 0);
      add_row("5\n0-00-10 12:00:00 01 x\r", 0, ST_OK, 0, 0, 0);        // lf dropped, month 0
      add_row("60-06-15 00:00:00 00 0 *", 0, ST_OK, 1, 0, 0);          // marker end, day back
      add_row("#*-05-05 05:05:05 05 #*\r", 0, ST_OK, 0, 0, 0);         // markers kept as text
      add_row("5-07-08 09:10:11 -3 x\r", 0, ST_OK, 0, 0, 1);           // nul lead, negative dst
      add_row("5-07-08 09:10:12 01 x#", 0, ST_OK, 1, 0, 1);            // one second on
      add_row("12-34\r", 1, ST_FORMAT_BAD, 0, 0, 0);
      add_row("1-02-03 04:05:06 07 x\r", 1, ST_FORMAT_BAD, 0, 0, 0);   // dash too early
      add_row("24-02-03 04-05:06 07 x\r", 1, ST_FORMAT_BAD, 0, 0, 0);
      add_row("24-02-03 04:05:06 07 \r", 1, ST_FORMAT_BAD, 0, 0, 0);   // one short
      add_row("24-13-03 04:05:06 07 x\r", 1, ST_RANGE_BAD, 0, 0, 0);
      add_row("24--1-03 04:05:06 07 x\r", 1, ST_RANGE_BAD, 0, 0, 0);   // negative month
      add_row("24-01-00 04:05:06 07 x\r", 1, ST_RANGE_BAD, 0, 0, 0);
      add_row("24-01-32 04:05:06 07 x\r", 1, ST_RANGE_BAD, 0, 0, 0);
      add_row("24-01-31 24:05:06 07 x\r", 1, ST_RANGE_BAD, 0, 0, 0);
      add_row("24-01-31 23:60:06 07 x\r", 1, ST_RANGE_BAD, 0, 0, 0);
      add_row("24-01-31 23:59:60 07 x\r", 1, ST_RANGE_BAD, 0, 0, 0);
      add_row(" +-+1- 2 +3:-0: 0 2a z\r", 0, ST_OK, 0, 0, 0);          // spaces and signs
      add_row("NO CARRIER", 1, ST_OVERFLOW, 0, LINE_MAX - 10, 0);      // overflow wins
      add_row("", 1, ST_OVERFLOW, 0, LINE_MAX, 0);
      add_row("\r", 1, ST_FORMAT_BAD, 0, 0, 0);                        // empty line
      add_row("\r", 1, ST_FORMAT_BAD, 0, LINE_MAX - 1, 0);             // longest legal line

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         line_q.delete();
         repeat (row.fill) line_q.push_back(FILL_CHAR);
         if (row.nul_first) line_q.push_back(8'h00);
         for (int k = 0; k < row.text.len(); k++) line_q.push_back(row.text[k]);
         send_line(line_q, row.mark, row.fixed, row.code);
      end

      // random phases, each under its own zone offset, extremes included
      zone_plan = '{14, -12, 15, -16, 0, 0, -7};
      zone_plan[5] = $urandom_range(0, 31) - 16;
      for (int ph = 0; ph < 7; ph++) begin
         set_zone(zone_plan[ph]);
         phase_start = sent_count;
         // an overflowing line whose remainder starts the next one
         if (ph == 0) begin
            line_q.delete();
            repeat ($urandom_range(LINE_MAX, LINE_MAX + 40)) line_q.push_back(text_char());
            line_q.push_back(CHAR_CR);
            send_line(line_q, 1'b0, 1'b0, ST_OK);
         end
         while (sent_count - phase_start < 50) begin
            if (ph == 1 && !paused && sent_count - phase_start > 20) begin
               drain_results();
               paused = 1'b1;
            end
            line_q.delete();
            m = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (r < 15) begin
               // raw noise, every byte value possible
               repeat ($urandom_range(1, 40)) line_q.push_back(8'($urandom_range(0, 255)));
               line_q.push_back(CHAR_CR);
            end else begin
               build_time_line(line_q, m);
            end
            send_line(line_q, m, 1'b0, ST_OK);
         end
      end

      // let every owed response arrive, then a little longer
      drain_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_lines.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
